/* hdl/itseq_pkg.sv */
package itseq_pkg;

    localparam int unsigned ACTION_W = 2;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CMD_W    = 3;
    localparam int unsigned PIDX_W   = 2;
    localparam int unsigned MODE_W   = 4;
    localparam int unsigned NPORTS   = 3;

    localparam logic [ACTION_W-1:0] ACT_TABLE  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_START  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_ADDR   = 2'd2;

    localparam logic [CMD_W-1:0] CMD_END   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_START = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ADDR  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_BYTE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_STOP  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_PORT  = 3'd5;

    localparam logic [MODE_W-1:0] MODE_COUNT       = 4'd0;
    localparam logic [MODE_W-1:0] MODE_PORT_LETTER = 4'd1;
    localparam logic [MODE_W-1:0] MODE_PORT_BIT    = 4'd2;
    localparam logic [MODE_W-1:0] MODE_PORT_VALUE  = 4'd3;
    localparam logic [MODE_W-1:0] MODE_ADDR        = 4'd4;
    localparam logic [MODE_W-1:0] MODE_WAIT_START  = 4'd5;
    localparam logic [MODE_W-1:0] MODE_WAIT_ADDR   = 4'd6;
    localparam logic [MODE_W-1:0] MODE_SUBADDR     = 4'd7;
    localparam logic [MODE_W-1:0] MODE_DATA        = 4'd8;

    localparam logic [BYTE_W-1:0] COUNT_END    = 8'd0;
    localparam logic [BYTE_W-1:0] COUNT_PORT   = 8'd255;
    localparam logic [BYTE_W-1:0] COUNT_HEADER = 8'd2;
    localparam logic [BYTE_W-1:0] LETTER_B     = 8'h42;
    localparam logic [BYTE_W-1:0] LETTER_C     = 8'h43;
    localparam logic [BYTE_W-1:0] LETTER_D     = 8'h44;
    localparam logic [BYTE_W-1:0] BYTE_ONES    = 8'hFF;

    localparam logic [PIDX_W-1:0] PORT_B = 2'd0;
    localparam logic [PIDX_W-1:0] PORT_C = 2'd1;
    localparam logic [PIDX_W-1:0] PORT_D = 2'd2;

    localparam int unsigned RQ_DEPTH = 4;
    localparam int unsigned RQ_AW    = $clog2(RQ_DEPTH);
    localparam int unsigned RQ_CW    = $clog2(RQ_DEPTH + 1);

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [BYTE_W-1:0] bus_byte;
        logic [PIDX_W-1:0] port_index;
        logic [BYTE_W-1:0] port_value;
        logic              last;
    } t_result;

    typedef struct packed {
        logic    push0;
        logic    push1;
        t_result res0;
        t_result res1;
    } t_push;

endpackage

/* hdl/itseq_in_if.sv */
interface itseq_in_if
    import itseq_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [BYTE_W-1:0]   table_byte;
    logic                bus_ok;

    modport source (output valid, output action, output table_byte, output bus_ok,
                    input ready);
    modport sink   (input valid, input action, input table_byte, input bus_ok,
                    output ready);
endinterface

/* hdl/itseq_out_if.sv */
interface itseq_out_if
    import itseq_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [BYTE_W-1:0] bus_byte;
    logic [PIDX_W-1:0] port_index;
    logic [BYTE_W-1:0] port_value;
    logic              last;

    modport source (output valid, output command, output bus_byte, output port_index,
                    output port_value, output last, input ready);
    modport sink   (input valid, input command, input bus_byte, input port_index,
                    input port_value, input last, output ready);
endinterface

/* hdl/i2c_init_table_sequencer.sv */
// I2C init table sequencer.
// Input channel i_in carries one word per table byte or bus status report
// (action, table_byte, bus_ok). Output channel o_out carries bus commands for
// the I2C master (command, bus_byte, port_index, port_value, last); last marks
// the final command that one input word causes, and each word causes none,
// one or two commands.
// A word taken into the input register is parsed once the result queue has
// room, and its commands are written into that queue, whose head o_out offers.
// Throughput: one input word per cycle while the result queue has room for
// two commands; o_out issues one command per cycle while its receiver is ready.
// The input register and parser advance only while the four-entry result
// queue has room for two commands, so a stalled receiver stops the parser once
// the queue holds three or more entries, and i_in.ready then drops; nothing is lost.
// Reset (i_rst_n low, synchronous) clears the queue, the input register, the
// parse state, the kept address and the three port images.
module i2c_init_table_sequencer
    import itseq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    itseq_in_if.sink    i_in,
    itseq_out_if.source o_out
);

    logic                r_in_valid;
    logic [ACTION_W-1:0] r_action;
    logic [BYTE_W-1:0]   r_table_byte;
    logic                r_bus_ok;
    logic                room2;
    logic                fire;
    t_push               push;
    t_result             head;

    assign fire       = r_in_valid & room2;
    assign i_in.ready = !r_in_valid | fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready & i_in.valid) begin
            r_action     <= i_in.action;
            r_table_byte <= i_in.table_byte;
            r_bus_ok     <= i_in.bus_ok;
        end
    end

    itseq_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_action     (r_action),
        .i_table_byte (r_table_byte),
        .i_bus_ok     (r_bus_ok),
        .o_push       (push)
    );

    itseq_rqueue u_rqueue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room2 (room2),
        .o_valid (o_out.valid),
        .o_data  (head),
        .i_ready (o_out.ready)
    );

    assign o_out.command    = head.command;
    assign o_out.bus_byte   = head.bus_byte;
    assign o_out.port_index = head.port_index;
    assign o_out.port_value = head.port_value;
    assign o_out.last       = head.last;

endmodule

/* hdl/itseq_parse.sv */
module itseq_parse
    import itseq_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  logic [ACTION_W-1:0] i_action,
    input  logic [BYTE_W-1:0]   i_table_byte,
    input  logic                i_bus_ok,
    output t_push               o_push
);

    logic [MODE_W-1:0] r_mode,    n_mode;
    logic [BYTE_W-1:0] r_left,    n_left;
    logic [BYTE_W-1:0] r_dev,     n_dev;
    logic [BYTE_W-1:0] r_letter,  n_letter;
    logic [BYTE_W-1:0] r_bitnum,  n_bitnum;
    logic [BYTE_W-1:0] r_img [NPORTS];

    logic              img_we;
    logic [PIDX_W-1:0] img_idx;
    logic [BYTE_W-1:0] img_new;
    logic              idx_ok;
    logic [BYTE_W-1:0] mask;
    logic [BYTE_W-1:0] left_dec;
    t_result           res0, res1;
    logic              push0, push1;

    always_comb begin
        idx_ok  = 1'b1;
        img_idx = PORT_B;
        priority if (r_letter == LETTER_B) begin
            img_idx = PORT_B;
        end else if (r_letter == LETTER_C) begin
            img_idx = PORT_C;
        end else if (r_letter == LETTER_D) begin
            img_idx = PORT_D;
        end else begin
            idx_ok = 1'b0;
        end
        mask = BYTE_W'(1) << r_bitnum[2:0];
        if (r_bitnum >= BYTE_W'(BYTE_W)) begin
            img_new = r_img[img_idx];
        end else if (i_table_byte != '0) begin
            img_new = r_img[img_idx] | mask;
        end else begin
            img_new = r_img[img_idx] & (mask ^ BYTE_ONES);
        end
    end

    always_comb begin
        n_mode   = r_mode;
        n_left   = r_left;
        n_dev    = r_dev;
        n_letter = r_letter;
        n_bitnum = r_bitnum;
        img_we   = 1'b0;
        push0    = 1'b0;
        push1    = 1'b0;
        res0     = '0;
        res1     = '0;
        left_dec = r_left - 8'd1;
        priority if (i_action == ACT_START) begin
            if (r_mode == MODE_WAIT_START) begin
                push0 = 1'b1;
                if (i_bus_ok) begin
                    res0.command  = CMD_ADDR;
                    res0.bus_byte = r_dev;
                    n_mode        = MODE_WAIT_ADDR;
                end else begin
                    res0.command = CMD_STOP;
                    push1        = 1'b1;
                    res1.command = CMD_START;
                end
            end
        end else if (i_action == ACT_ADDR) begin
            if (r_mode == MODE_WAIT_ADDR) begin
                if (i_bus_ok) begin
                    n_mode = MODE_SUBADDR;
                end else begin
                    push0        = 1'b1;
                    res0.command = CMD_STOP;
                    push1        = 1'b1;
                    res1.command = CMD_START;
                    n_mode       = MODE_WAIT_START;
                end
            end
        end else if (i_action == ACT_TABLE) begin
            unique case (r_mode)
                MODE_COUNT: begin
                    priority if (i_table_byte == COUNT_END) begin
                        push0        = 1'b1;
                        res0.command = CMD_END;
                    end else if (i_table_byte == COUNT_PORT) begin
                        n_mode = MODE_PORT_LETTER;
                    end else begin
                        n_left = i_table_byte - COUNT_HEADER;
                        n_mode = MODE_ADDR;
                    end
                end
                MODE_PORT_LETTER: begin
                    n_letter = i_table_byte;
                    n_mode   = MODE_PORT_BIT;
                end
                MODE_PORT_BIT: begin
                    n_bitnum = i_table_byte;
                    n_mode   = MODE_PORT_VALUE;
                end
                MODE_PORT_VALUE: begin
                    n_mode = MODE_COUNT;
                    if (idx_ok) begin
                        img_we          = 1'b1;
                        push0           = 1'b1;
                        res0.command    = CMD_PORT;
                        res0.port_index = img_idx;
                        res0.port_value = img_new;
                    end
                end
                MODE_ADDR: begin
                    n_dev        = i_table_byte;
                    push0        = 1'b1;
                    res0.command = CMD_START;
                    n_mode       = MODE_WAIT_START;
                end
                MODE_SUBADDR, MODE_DATA: begin
                    push0         = 1'b1;
                    res0.command  = CMD_BYTE;
                    res0.bus_byte = i_table_byte;
                    if (r_mode == MODE_DATA) begin
                        n_left = left_dec;
                    end
                    if (n_left == '0) begin
                        push1        = 1'b1;
                        res1.command = CMD_STOP;
                        n_mode       = MODE_COUNT;
                    end else begin
                        n_mode = MODE_DATA;
                    end
                end
                MODE_WAIT_START, MODE_WAIT_ADDR: begin
                end
                default: begin
                    n_mode = MODE_COUNT;
                end
            endcase
        end else begin
        end
        res0.last = !push1;
        res1.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_COUNT;
            r_left   <= '0;
            r_dev    <= '0;
            r_letter <= '0;
            r_bitnum <= '0;
            for (int i = 0; i < NPORTS; i++) begin
                r_img[i] <= '0;
            end
        end else if (i_fire) begin
            r_mode   <= n_mode;
            r_left   <= n_left;
            r_dev    <= n_dev;
            r_letter <= n_letter;
            r_bitnum <= n_bitnum;
            if (img_we) begin
                r_img[img_idx] <= img_new;
            end
        end
    end

    assign o_push.push0 = i_fire & push0;
    assign o_push.push1 = i_fire & push1;
    assign o_push.res0  = res0;
    assign o_push.res1  = res1;

endmodule

/* hdl/itseq_rqueue.sv */
module itseq_rqueue
    import itseq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    output logic    o_room2,
    output logic    o_valid,
    output t_result o_data,
    input  logic    i_ready
);

    t_result          r_mem [RQ_DEPTH];
    logic [RQ_AW-1:0] r_wr, n_wr;
    logic [RQ_AW-1:0] r_rd, n_rd;
    logic [RQ_CW-1:0] r_count, n_count;
    logic             pop;
    logic [RQ_AW-1:0] wr_next;

    assign pop     = o_valid & i_ready;
    assign wr_next = r_wr + RQ_AW'(1);

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push.push0) begin
            n_wr = n_wr + RQ_AW'(1);
        end
        if (i_push.push1) begin
            n_wr = n_wr + RQ_AW'(1);
        end
        if (pop) begin
            n_rd = r_rd + RQ_AW'(1);
        end
        n_count = r_count + RQ_CW'(i_push.push0) + RQ_CW'(i_push.push1) - RQ_CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push0) begin
            r_mem[r_wr] <= i_push.res0;
        end
        if (i_push.push1) begin
            r_mem[wr_next] <= i_push.res1;
        end
    end

    assign o_room2 = r_count <= RQ_CW'(RQ_DEPTH - 2);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd];

endmodule
